// ===== rtl/contiguous_page_allocator_assert.svh =====
// ----------------------------------------------------------------------------
// contiguous_page_allocator_assert.svh
// assertion macros used by the allocator checker
// ----------------------------------------------------------------------------
`ifndef CONTIGUOUS_PAGE_ALLOCATOR_ASSERT_SVH
`define CONTIGUOUS_PAGE_ALLOCATOR_ASSERT_SVH

// same-cycle implication, gated by the active-low reset
`define CPA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cpa assertion failed");

// next-cycle implication, gated by the active-low reset
`define CPA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cpa assertion failed");

`endif

// ===== rtl/cpa_pkg.sv =====
// ----------------------------------------------------------------------------
// cpa_pkg
// types and constants of the contiguous page allocator
// ----------------------------------------------------------------------------
`default_nettype none

package cpa_pkg;

  localparam int unsigned ACTION_W = 2;
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned ID_W     = 8;
  localparam int unsigned BYTES_W  = 23;
  localparam int unsigned QPAGE_W  = 10;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned ADDR_W   = 22;
  localparam int unsigned CFG_W    = 11;

  // usable page count after reset
  localparam logic [CFG_W-1:0] USABLE_RESET = 11'd1000;

  typedef enum logic [ACTION_W-1:0] {
    ACT_ALLOC = 2'd0,
    ACT_FREE  = 2'd1,
    ACT_QUERY = 2'd2
  } action_e;

  typedef enum logic [MODE_W-1:0] {
    FIT_FIRST   = 2'd0,
    FIT_BEST    = 2'd1,
    FIT_WORST   = 2'd2,
    FIT_INVALID = 2'd3
  } fit_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_NO_SPACE  = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_INVALID   = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_ASCAN,
    S_AWRITE,
    S_FREE,
    S_QREAD,
    S_RESP
  } state_e;

  // request word
  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [MODE_W-1:0]   fit_mode;
    logic [ID_W-1:0]     proc_id;
    logic [BYTES_W-1:0]  request_bytes;
    logic [QPAGE_W-1:0]  query_page;
  } req_t;

  // response word
  typedef struct packed {
    status_e             status;
    logic [ADDR_W-1:0]   start_address;
    logic                page_in_use;
    logic [ID_W-1:0]     page_owner;
  } rsp_t;

endpackage

`default_nettype wire

// ===== rtl/cpa_if.sv =====
// ----------------------------------------------------------------------------
// cpa_if
// valid/ready channels carrying request and response words
// ----------------------------------------------------------------------------
`default_nettype none

interface cpa_req_if;
  import cpa_pkg::*;

  logic valid;
  logic ready;
  req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface cpa_rsp_if;
  import cpa_pkg::*;

  logic valid;
  logic ready;
  rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/contiguous_page_allocator.sv =====
// allocate: a page map scan up to min(usable_pages, PAGE_COUNT), then the chosen run is
// written page by page until the request is covered.
// free: a walk over the whole page map, one page map read per cycle; query: one entry read.
// one request at a time; the page map ram's single read port sets the scan rate.
// reset: asynchronous, active low; the page map is then cleared, during which no request
// is taken (configuration writes are taken).
// ----------------------------------------------------------------------------
// contiguous_page_allocator
// first, best and worst fit allocator over a page map held in ram; a shared
// add/compare unit sizes free runs and totals the bytes written
// ----------------------------------------------------------------------------
`default_nettype none

module contiguous_page_allocator #(
  parameter int unsigned PAGE_COUNT = 1024,
  parameter int unsigned PAGE_BYTES = 4096
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [cpa_pkg::CFG_W-1:0] cfg_wdata_i,
  cpa_req_if.sink                   req_i,
  cpa_rsp_if.source                 rsp_o
);

  import cpa_pkg::*;

  localparam int unsigned AW = $clog2(PAGE_COUNT);
  localparam int unsigned PW = $clog2(PAGE_COUNT + 1);
  localparam longint unsigned MAXB = longint'(PAGE_COUNT) * longint'(PAGE_BYTES);
  localparam int unsigned RBW = $clog2(MAXB + 1);
  localparam int unsigned CW = (RBW > BYTES_W) ? RBW : BYTES_W;
  localparam int unsigned LW = (PW > CFG_W) ? PW : CFG_W;
  localparam int unsigned QW = (PW > QPAGE_W) ? PW : QPAGE_W;
  localparam int unsigned EW = ID_W + 1;

  localparam logic [CW-1:0]     PB_C = CW'(PAGE_BYTES);
  localparam logic [ADDR_W-1:0] PB_A = ADDR_W'(PAGE_BYTES);
  localparam logic [PW-1:0]     LAST_PAGE = PW'(PAGE_COUNT - 1);

  state_e            state_q, state_d;
  logic [CFG_W-1:0]  usable_q;
  req_t              req_q, req_d;
  logic [PW-1:0]     p_q, p_d;
  logic [PW-1:0]     pp_q, pp_d;
  logic              pv_q, pv_d;
  logic [ADDR_W-1:0] pa_q, pa_d;
  logic [AW-1:0]     run_start_q, run_start_d;
  logic [ADDR_W-1:0] run_addr_q, run_addr_d;
  logic [PW-1:0]     run_len_q, run_len_d;
  logic [RBW-1:0]    run_bytes_q, run_bytes_d;
  logic              run_fits_q, run_fits_d;
  logic              found_q, found_d;
  logic [AW-1:0]     best_start_q, best_start_d;
  logic [ADDR_W-1:0] best_addr_q, best_addr_d;
  logic [PW-1:0]     best_len_q, best_len_d;
  logic              hit_q, hit_d;
  logic [AW-1:0]     wp_q, wp_d;
  logic [RBW-1:0]    wb_q, wb_d;
  rsp_t              res_q, res_d;
  logic              out_valid_q, out_valid_d;
  rsp_t              out_data_q, out_data_d;
  logic              out_load;

  logic              accept;
  logic [LW-1:0]     usable_ext;
  logic [LW-1:0]     count_ext;
  logic [PW-1:0]     limit;
  logic              q_in_range;
  logic              free_pg;
  logic              take;

  // shared add/compare unit
  logic [RBW-1:0]    add_a;
  logic [CW-1:0]     sum;
  logic              fits;

  // page map ram ports
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [EW-1:0]     ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [EW-1:0]     ram_rdata;
  logic              rd_used;
  logic [ID_W-1:0]   rd_owner;

  cpa_ram #(
    .WIDTH (EW),
    .DEPTH (PAGE_COUNT)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd_used  = ram_rdata[ID_W];
  assign rd_owner = ram_rdata[ID_W-1:0];

  // handshake
  assign req_i.ready = (state_q == S_IDLE);
  assign accept      = req_i.valid && req_i.ready;
  assign rsp_o.valid = out_valid_q;
  assign rsp_o.data  = out_data_q;

  // usable limit, clamped to the map size
  assign usable_ext = LW'(usable_q);
  assign count_ext  = LW'(PAGE_COUNT);
  assign limit      = (usable_ext > count_ext) ? PW'(count_ext) : PW'(usable_ext);
  assign q_in_range = QW'(req_q.query_page) < QW'(PAGE_COUNT);

  // run size or written size plus one page, checked against the request
  assign sum  = CW'(add_a) + PB_C;
  assign fits = sum >= CW'(req_q.request_bytes);

  // page under test is free and inside the limit
  assign free_pg = (pp_q < limit) && !rd_used;

  // replace the chosen run with the one just closed
  always_comb begin
    case (req_q.fit_mode)
      FIT_BEST:  take = !found_q || (run_len_q < best_len_q);
      FIT_WORST: take = !found_q || (run_len_q > best_len_q);
      default:   take = !found_q;
    endcase
  end

  // sequencer
  always_comb begin
    state_d      = state_q;
    req_d        = req_q;
    p_d          = p_q;
    pp_d         = pp_q;
    pv_d         = 1'b0;
    pa_d         = pa_q;
    run_start_d  = run_start_q;
    run_addr_d   = run_addr_q;
    run_len_d    = run_len_q;
    run_bytes_d  = run_bytes_q;
    run_fits_d   = run_fits_q;
    found_d      = found_q;
    best_start_d = best_start_q;
    best_addr_d  = best_addr_q;
    best_len_d   = best_len_q;
    hit_d        = hit_q;
    wp_d         = wp_q;
    wb_d         = wb_q;
    res_d        = res_q;
    out_load     = 1'b0;
    add_a        = '0;
    ram_we       = 1'b0;
    ram_waddr    = p_q[AW-1:0];
    ram_wdata    = '0;
    ram_raddr    = p_q[AW-1:0];

    case (state_q)
      // sweep zeros through the page map
      S_CLEAR: begin
        ram_we = 1'b1;
        p_d    = p_q + PW'(1);
        if (p_q == LAST_PAGE) begin
          state_d = S_IDLE;
        end
      end

      // take a request word and dispatch
      S_IDLE: begin
        if (accept) begin
          req_d      = req_i.data;
          p_d        = '0;
          pa_d       = '0;
          run_len_d  = '0;
          run_fits_d = 1'b0;
          found_d    = 1'b0;
          hit_d      = 1'b0;
          res_d      = '0;
          case (req_i.data.action)
            ACT_ALLOC: begin
              if (req_i.data.fit_mode == FIT_INVALID) begin
                res_d.status = ST_INVALID;
                state_d      = S_RESP;
              end else begin
                state_d = S_ASCAN;
              end
            end
            ACT_FREE:  state_d = S_FREE;
            ACT_QUERY: state_d = S_QREAD;
            default: begin
              res_d.status = ST_INVALID;
              state_d      = S_RESP;
            end
          endcase
        end
      end

      // walk pages 0..limit, the limit itself closes the last run
      S_ASCAN: begin
        p_d   = p_q + PW'(1);
        pp_d  = p_q;
        pv_d  = 1'b1;
        add_a = (run_len_q == '0) ? '0 : run_bytes_q;
        if (pv_q) begin
          pa_d = pa_q + PB_A;
          if (free_pg) begin
            if (run_len_q == '0) begin
              run_start_d = pp_q[AW-1:0];
              run_addr_d  = pa_q;
            end
            run_len_d   = run_len_q + PW'(1);
            run_bytes_d = RBW'(sum);
            run_fits_d  = fits;
          end else begin
            if ((run_len_q != '0) && run_fits_q && take) begin
              found_d      = 1'b1;
              best_start_d = run_start_q;
              best_addr_d  = run_addr_q;
              best_len_d   = run_len_q;
            end
            run_len_d = '0;
          end
          if (pp_q == limit) begin
            pv_d = 1'b0;
            if (found_d) begin
              wp_d                = best_start_d;
              wb_d                = '0;
              res_d.start_address = best_addr_d;
              state_d             = S_AWRITE;
            end else begin
              res_d.status = ST_NO_SPACE;
              state_d      = S_RESP;
            end
          end
        end
      end

      // claim pages until the request is covered
      S_AWRITE: begin
        add_a     = wb_q;
        ram_we    = 1'b1;
        ram_waddr = wp_q;
        ram_wdata = {1'b1, req_q.proc_id};
        wp_d      = wp_q + AW'(1);
        wb_d      = RBW'(sum);
        if (fits) begin
          state_d = S_RESP;
        end
      end

      // release every page of the id, reading one page ahead of the write
      S_FREE: begin
        p_d  = p_q + PW'(1);
        pp_d = p_q;
        pv_d = 1'b1;
        if (pv_q) begin
          if (rd_used && (rd_owner == req_q.proc_id)) begin
            ram_we    = 1'b1;
            ram_waddr = pp_q[AW-1:0];
            hit_d     = 1'b1;
          end
          if (pp_q == LAST_PAGE) begin
            pv_d         = 1'b0;
            res_d.status = hit_d ? ST_OK : ST_NOT_FOUND;
            state_d      = S_RESP;
          end
        end
      end

      // read one page entry
      S_QREAD: begin
        ram_raddr = AW'(req_q.query_page);
        pv_d      = 1'b1;
        if (pv_q) begin
          pv_d = 1'b0;
          if (q_in_range && rd_used) begin
            res_d.page_in_use = 1'b1;
            res_d.page_owner  = rd_owner;
          end
          state_d = S_RESP;
        end
      end

      // hand the result to the output register
      S_RESP: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (out_load) begin
      out_valid_d = 1'b1;
      out_data_d  = res_q;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      usable_q    <= USABLE_RESET;
      p_q         <= '0;
      pv_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      p_q         <= p_d;
      pv_q        <= pv_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        usable_q <= cfg_wdata_i;
      end
    end
  end

  // working registers, set up when a request is taken
  always_ff @(posedge clk_i) begin
    req_q        <= req_d;
    pp_q         <= pp_d;
    pa_q         <= pa_d;
    run_start_q  <= run_start_d;
    run_addr_q   <= run_addr_d;
    run_len_q    <= run_len_d;
    run_bytes_q  <= run_bytes_d;
    run_fits_q   <= run_fits_d;
    found_q      <= found_d;
    best_start_q <= best_start_d;
    best_addr_q  <= best_addr_d;
    best_len_q   <= best_len_d;
    hit_q        <= hit_d;
    wp_q         <= wp_d;
    wb_q         <= wb_d;
    res_q        <= res_d;
    out_data_q   <= out_data_d;
  end

endmodule

`default_nettype wire

// ===== rtl/cpa_ram.sv =====
// ----------------------------------------------------------------------------
// cpa_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none

module cpa_ram #(
  parameter int unsigned WIDTH = 9,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/cpa_checker.sv =====
// ----------------------------------------------------------------------------
// cpa_checker
// port-level checks of the allocator, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "contiguous_page_allocator_assert.svh"

module cpa_checker (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  input  logic          req_ready_i,
  input  logic          rsp_valid_i,
  input  logic          rsp_ready_i,
  input  cpa_pkg::rsp_t rsp_data_i
);

  import cpa_pkg::*;

  // a held response word stays up and unchanged
  `CPA_ASSERT_NXT(a_rsp_hold, clk_i, rst_ni, rsp_valid_i && !rsp_ready_i, rsp_valid_i)
  `CPA_ASSERT_NXT(a_rsp_stable, clk_i, rst_ni, rsp_valid_i && !rsp_ready_i, $stable(rsp_data_i))

  // a taken request keeps the block busy for at least the next cycle
  `CPA_ASSERT_NXT(a_busy_after_req, clk_i, rst_ni, req_valid_i && req_ready_i, !req_ready_i)

  // a new response only comes out of a busy cycle
  `CPA_ASSERT_IMP(a_rsp_from_busy, clk_i, rst_ni, $rose(rsp_valid_i), $past(!req_ready_i))

endmodule

bind contiguous_page_allocator cpa_checker u_cpa_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_i.valid),
  .req_ready_i (req_i.ready),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready),
  .rsp_data_i  (rsp_o.data)
);

`default_nettype wire
